// ===== rtl/indexed_list_engine_macros.svh =====
// Assertion macros shared by the indexed list engine checkers.
// Depends on nothing; included by the checker file.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ILE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ILE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ile_pkg.sv =====
// Package for the indexed list engine: transaction payload types,
// operation and status codes, and sequencer state types. No dependencies.
package ile_pkg;

   localparam int VALUE_BITS = 32;

   localparam logic [3:0] OP_INSERT  = 4'd0;
   localparam logic [3:0] OP_REPLACE = 4'd1;
   localparam logic [3:0] OP_DELETE  = 4'd2;
   localparam logic [3:0] OP_TAKE    = 4'd3;
   localparam logic [3:0] OP_PUSH    = 4'd4;
   localparam logic [3:0] OP_POP     = 4'd5;
   localparam logic [3:0] OP_FIND    = 4'd6;
   localparam logic [3:0] OP_READ    = 4'd7;
   localparam logic [3:0] OP_CLEAR   = 4'd8;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   typedef struct packed {
      logic [3:0]            operation;
      logic [3:0]            position;
      logic [VALUE_BITS-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value_out;
      logic [3:0]            match_index;
      logic                  hit;
      logic [4:0]            entry_count;
      logic [1:0]            status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_FLUSH,
      S_PUT,
      S_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      MODE_UP,
      MODE_DOWN,
      MODE_FIND,
      MODE_READ
   } mode_type;

endpackage

// ===== rtl/ile_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ile_seq.sv =====
// Sequencer of the indexed list engine: decodes a request, sweeps the entry
// RAM one read per cycle to shift, scan or fetch, and holds the result.
// Depends on ile_pkg.
module ile_seq #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ile_pkg::req_type         req_payload,
   output logic                     res_valid,
   input  logic                     res_ready,
   output ile_pkg::rsp_type         res_payload,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [WORD_BITS-1:0]     ram_wr_data,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  logic [WORD_BITS-1:0]     ram_rd_data
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PCW = (CW > 4) ? CW : 4;
   localparam int VB  = (WORD_BITS < ile_pkg::VALUE_BITS) ? WORD_BITS : ile_pkg::VALUE_BITS;

   ile_pkg::seq_state_type state_ff, state_in;
   ile_pkg::mode_type      mode_ff, mode_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [AW-1:0]          last_ff, last_in;
   logic [AW-1:0]          p_ff, p_in;
   logic [WORD_BITS-1:0]   val_ff, val_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rv_ff, rv_in;
   logic [AW-1:0]          ra_ff, ra_in;
   logic [WORD_BITS-1:0]   vout_ff, vout_in;
   logic [AW-1:0]          midx_ff, midx_in;
   logic                   hit_ff, hit_in;
   logic [1:0]             status_ff, status_in;

   logic                   in_range;
   logic                   full;
   logic                   empty;
   logic [AW-1:0]          last_idx;
   logic [AW-1:0]          pos_idx;
   logic [AW-1:0]          end_idx;

   assign in_range = PCW'(req_payload.position) < PCW'(cnt_ff);
   assign full     = cnt_ff == CW'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign last_idx = AW'(cnt_ff - CW'(1));
   assign pos_idx  = AW'(req_payload.position);
   assign end_idx  = AW'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ile_pkg::S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      p_ff      <= p_in;
      val_ff    <= val_in;
      ra_ff     <= ra_in;
      vout_ff   <= vout_in;
      midx_ff   <= midx_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      p_in        = p_ff;
      val_in      = val_ff;
      cnt_in      = cnt_ff;
      rv_in       = 1'b0;
      ra_in       = ra_ff;
      vout_in     = vout_ff;
      midx_in     = midx_ff;
      hit_in      = hit_ff;
      status_in   = status_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = p_ff;
      ram_wr_data = val_ff;
      ram_rd_addr = idx_ff;

      // Read data returns in the cycle after its address was issued.
      if (rv_ff) begin
         case (mode_ff)
            ile_pkg::MODE_UP: begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(ra_ff + AW'(1));
               ram_wr_data = ram_rd_data;
            end
            ile_pkg::MODE_DOWN: begin
               if (ra_ff == p_ff) begin
                  vout_in = ram_rd_data;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = AW'(ra_ff - AW'(1));
                  ram_wr_data = ram_rd_data;
               end
            end
            ile_pkg::MODE_FIND: begin
               if (!hit_ff && ram_rd_data == val_ff) begin
                  hit_in  = 1'b1;
                  midx_in = ra_ff;
               end
            end
            ile_pkg::MODE_READ: begin
               vout_in = ram_rd_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ile_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in    = WORD_BITS'(req_payload.value_in[VB-1:0]);
               vout_in   = '0;
               midx_in   = '0;
               hit_in    = 1'b0;
               status_in = ile_pkg::STATUS_OK;
               state_in  = ile_pkg::S_DONE;
               case (req_payload.operation)
                  ile_pkg::OP_INSERT: begin
                     if (full) begin
                        status_in = ile_pkg::STATUS_FULL;
                     end else begin
                        cnt_in = cnt_ff + CW'(1);
                        if (in_range) begin
                           p_in     = pos_idx;
                           mode_in  = ile_pkg::MODE_UP;
                           idx_in   = last_idx;
                           last_in  = pos_idx;
                           state_in = ile_pkg::S_SWEEP;
                        end else begin
                           p_in     = end_idx;
                           state_in = ile_pkg::S_PUT;
                        end
                     end
                  end
                  ile_pkg::OP_REPLACE: begin
                     if (in_range) begin
                        p_in     = pos_idx;
                        state_in = ile_pkg::S_PUT;
                     end else if (full) begin
                        status_in = ile_pkg::STATUS_FULL;
                     end else begin
                        cnt_in   = cnt_ff + CW'(1);
                        p_in     = end_idx;
                        state_in = ile_pkg::S_PUT;
                     end
                  end
                  ile_pkg::OP_DELETE: begin
                     if (empty) begin
                        status_in = ile_pkg::STATUS_EMPTY;
                     end else if (!in_range) begin
                        status_in = ile_pkg::STATUS_RANGE;
                     end else begin
                        cnt_in   = cnt_ff - CW'(1);
                        p_in     = pos_idx;
                        mode_in  = ile_pkg::MODE_DOWN;
                        idx_in   = pos_idx;
                        last_in  = last_idx;
                        state_in = ile_pkg::S_SWEEP;
                     end
                  end
                  ile_pkg::OP_TAKE: begin
                     if (empty) begin
                        status_in = ile_pkg::STATUS_EMPTY;
                     end else begin
                        cnt_in   = cnt_ff - CW'(1);
                        hit_in   = 1'b1;
                        p_in     = in_range ? pos_idx : last_idx;
                        mode_in  = ile_pkg::MODE_DOWN;
                        idx_in   = in_range ? pos_idx : last_idx;
                        last_in  = last_idx;
                        state_in = ile_pkg::S_SWEEP;
                     end
                  end
                  ile_pkg::OP_PUSH: begin
                     if (full) begin
                        status_in = ile_pkg::STATUS_FULL;
                     end else begin
                        cnt_in = cnt_ff + CW'(1);
                        p_in   = '0;
                        if (empty) begin
                           state_in = ile_pkg::S_PUT;
                        end else begin
                           mode_in  = ile_pkg::MODE_UP;
                           idx_in   = last_idx;
                           last_in  = '0;
                           state_in = ile_pkg::S_SWEEP;
                        end
                     end
                  end
                  ile_pkg::OP_POP: begin
                     if (empty) begin
                        status_in = ile_pkg::STATUS_EMPTY;
                     end else begin
                        cnt_in   = cnt_ff - CW'(1);
                        hit_in   = 1'b1;
                        p_in     = '0;
                        mode_in  = ile_pkg::MODE_DOWN;
                        idx_in   = '0;
                        last_in  = last_idx;
                        state_in = ile_pkg::S_SWEEP;
                     end
                  end
                  ile_pkg::OP_FIND: begin
                     if (!empty) begin
                        mode_in  = ile_pkg::MODE_FIND;
                        idx_in   = '0;
                        last_in  = last_idx;
                        state_in = ile_pkg::S_SWEEP;
                     end
                  end
                  ile_pkg::OP_READ: begin
                     if (in_range) begin
                        hit_in   = 1'b1;
                        mode_in  = ile_pkg::MODE_READ;
                        idx_in   = pos_idx;
                        last_in  = pos_idx;
                        state_in = ile_pkg::S_SWEEP;
                     end else begin
                        status_in = ile_pkg::STATUS_RANGE;
                     end
                  end
                  ile_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ile_pkg::S_SWEEP: begin
            rv_in = 1'b1;
            ra_in = idx_ff;
            if (idx_ff == last_ff) begin
               state_in = ile_pkg::S_FLUSH;
            end else if (mode_ff == ile_pkg::MODE_UP) begin
               idx_in = AW'(idx_ff - AW'(1));
            end else begin
               idx_in = AW'(idx_ff + AW'(1));
            end
         end
         ile_pkg::S_FLUSH: begin
            state_in = (mode_ff == ile_pkg::MODE_UP) ? ile_pkg::S_PUT : ile_pkg::S_DONE;
         end
         ile_pkg::S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = p_ff;
            ram_wr_data = val_ff;
            state_in    = ile_pkg::S_DONE;
         end
         ile_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ile_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ile_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      res_payload.value_out   = hit_ff ? ile_pkg::VALUE_BITS'(vout_ff[VB-1:0]) : '0;
      res_payload.match_index = 4'(midx_ff);
      res_payload.hit         = hit_ff;
      res_payload.entry_count = 5'(cnt_ff);
      res_payload.status      = status_ff;
   end

endmodule

// ===== rtl/indexed_list_engine.sv =====
// Indexed list engine: entries live in one RAM with a registered read.
// A transaction passes the sequencer's idle and done states, plus a put state for a
// single-entry write, plus sweep and flush states for a sweep over n entries through the
// one RAM read port (insert at p: n = count - p, delete/take at p: n = count - p,
// find: n = count, read: 1). Results reach rsp through an output register.
// Synchronous reset empties the list and the output register; RAM contents are not cleared.
module indexed_list_engine #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ile_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ile_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   logic                 res_valid;
   logic                 res_ready;
   ile_pkg::rsp_type     res_payload;

   logic                 rsp_valid_ff, rsp_valid_in;
   ile_pkg::rsp_type     rsp_payload_ff, rsp_payload_in;

   ile_seq #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ile_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_payload;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/ile_check.sv =====
// Port-level checker for the indexed list engine, bound to the top level.
// Depends on ile_pkg and indexed_list_engine_macros.svh.
`include "indexed_list_engine_macros.svh"

module ile_check #(
   parameter int DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ile_pkg::rsp_type rsp_payload
);

   `ILE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "Stalled response transaction changed.")
   `ILE_ASSERT_IMP(a_hit_ok, clock, reset, rsp_valid && rsp_payload.hit, rsp_payload.status == ile_pkg::STATUS_OK, "Hit reported with a failing status.")
   `ILE_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_payload.hit, rsp_payload.value_out == '0 && rsp_payload.match_index == '0, "Miss carries nonzero data.")
   `ILE_ASSERT_IMP(a_full_count, clock, reset, rsp_valid && rsp_payload.status == ile_pkg::STATUS_FULL, rsp_payload.entry_count == 5'(DEPTH), "Full status with a list that is not full.")

endmodule

bind indexed_list_engine ile_check #(
   .DEPTH (DEPTH)
) u_ile_check (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== verif/indexed_list_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the indexed list engine: keeps its own copy of the list and
// predicts one response for each accepted request, then compares in order.
// Depends on ile_pkg for the payload types and the operation and status codes.
module indexed_list_checker #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ile_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ile_pkg::rsp_type rsp_payload,
   output int               mismatches,
   output int               outstanding,
   output int               checked_count,
   output int               full_drops,
   output int               empty_misses
);

   logic [ile_pkg::VALUE_BITS-1:0] list_words [DEPTH];
   int                             list_len;
   ile_pkg::rsp_type               expected_q [$];

   function automatic void open_slot(input int at,
                                     input logic [ile_pkg::VALUE_BITS-1:0] word);
      for (int i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
      list_words[at] = word;
      list_len++;
   endfunction

   function automatic logic [ile_pkg::VALUE_BITS-1:0] close_slot(input int at);
      logic [ile_pkg::VALUE_BITS-1:0] word;
      word = list_words[at];
      for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
      list_len--;
      return word;
   endfunction

   function automatic ile_pkg::rsp_type apply_request(input ile_pkg::req_type rq);
      ile_pkg::rsp_type rs;
      logic             full;
      logic             in_range;
      int               pos;
      rs       = '0;
      pos      = int'(rq.position);
      full     = (list_len >= DEPTH);
      in_range = (pos < list_len);
      case (rq.operation)
         ile_pkg::OP_INSERT: begin
            if (full) rs.status = ile_pkg::STATUS_FULL;
            else open_slot(in_range ? pos : list_len, rq.value_in);
         end
         ile_pkg::OP_REPLACE: begin
            if (in_range) list_words[pos] = rq.value_in;
            else if (full) rs.status = ile_pkg::STATUS_FULL;
            else open_slot(list_len, rq.value_in);
         end
         ile_pkg::OP_DELETE: begin
            if (list_len == 0) rs.status = ile_pkg::STATUS_EMPTY;
            else if (!in_range) rs.status = ile_pkg::STATUS_RANGE;
            else void'(close_slot(pos));
         end
         ile_pkg::OP_TAKE: begin
            if (list_len == 0) begin
               rs.status = ile_pkg::STATUS_EMPTY;
            end else begin
               rs.value_out = close_slot(in_range ? pos : list_len - 1);
               rs.hit       = 1'b1;
            end
         end
         ile_pkg::OP_PUSH: begin
            if (full) rs.status = ile_pkg::STATUS_FULL;
            else open_slot(0, rq.value_in);
         end
         ile_pkg::OP_POP: begin
            if (list_len == 0) begin
               rs.status = ile_pkg::STATUS_EMPTY;
            end else begin
               rs.value_out = close_slot(0);
               rs.hit       = 1'b1;
            end
         end
         ile_pkg::OP_FIND: begin
            for (int i = 0; i < list_len; i++) begin
               if (!rs.hit && list_words[i] == rq.value_in) begin
                  rs.match_index = 4'(i);
                  rs.hit         = 1'b1;
               end
            end
         end
         ile_pkg::OP_READ: begin
            if (in_range) begin
               rs.value_out = list_words[pos];
               rs.hit       = 1'b1;
            end else begin
               rs.status = ile_pkg::STATUS_RANGE;
            end
         end
         ile_pkg::OP_CLEAR: list_len = 0;
         default: ;
      endcase
      rs.entry_count = 5'(list_len);
      return rs;
   endfunction

   function automatic void compare_field(input string field,
                                         input logic [ile_pkg::VALUE_BITS-1:0] want,
                                         input logic [ile_pkg::VALUE_BITS-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      ile_pkg::rsp_type want;
      if (reset) begin
         list_len      = 0;
         mismatches    = 0;
         checked_count = 0;
         full_drops    = 0;
         empty_misses  = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: expected no response, got %h", $time, rsp_payload);
            end else begin
               want = expected_q.pop_front();
               checked_count++;
               compare_field("value_out", want.value_out, rsp_payload.value_out);
               compare_field("match_index",
                             ile_pkg::VALUE_BITS'(want.match_index),
                             ile_pkg::VALUE_BITS'(rsp_payload.match_index));
               compare_field("hit",
                             ile_pkg::VALUE_BITS'(want.hit),
                             ile_pkg::VALUE_BITS'(rsp_payload.hit));
               compare_field("entry_count",
                             ile_pkg::VALUE_BITS'(want.entry_count),
                             ile_pkg::VALUE_BITS'(rsp_payload.entry_count));
               compare_field("status",
                             ile_pkg::VALUE_BITS'(want.status),
                             ile_pkg::VALUE_BITS'(rsp_payload.status));
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(req_payload);
            if (want.status == ile_pkg::STATUS_FULL) full_drops++;
            if (want.status == ile_pkg::STATUS_EMPTY) empty_misses++;
            expected_q.push_back(want);
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the indexed list engine testbench: clock, reset, request and response
// drivers, and the verdict. Depends on ile_pkg, indexed_list_engine and indexed_list_checker.
module testbench;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   localparam int PHASE_ITEMS  = 545;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [3:0] OP_UNUSED_TOP = 4'd15;
   localparam logic [3:0] OP_ORDER [9] = '{ile_pkg::OP_INSERT, ile_pkg::OP_REPLACE,
                                          ile_pkg::OP_DELETE, ile_pkg::OP_TAKE,
                                          ile_pkg::OP_PUSH, ile_pkg::OP_POP,
                                          ile_pkg::OP_FIND, ile_pkg::OP_READ,
                                          ile_pkg::OP_CLEAR};

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             rsp_ready   = 1'b0;
   logic             rsp_hold    = 1'b0;
   logic             hold_go     = 1'b0;
   ile_pkg::req_type req_payload = '0;
   logic             req_ready;
   logic             rsp_valid;
   ile_pkg::rsp_type rsp_payload;

   int send_idle  = 16;
   int recv_idle  = 86;
   int items_sent = 0;
   int mismatches, outstanding, checked_count, full_drops, empty_misses;

   logic [ile_pkg::VALUE_BITS-1:0] word_pool [8];

   indexed_list_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   indexed_list_checker list_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial forever begin
      @(posedge clock);
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      @(negedge reset);
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("No transaction for %0d cycles, giving up.", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_req(input logic [3:0] op, input logic [3:0] pos,
                           input logic [ile_pkg::VALUE_BITS-1:0] word);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ile_pkg::req_type'{operation: op, position: pos, value_in: word};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [ile_pkg::VALUE_BITS-1:0] pick_word(input int pool_pct);
      if ($urandom_range(99) < pool_pct) return word_pool[$urandom_range(7)];
      return $urandom();
   endfunction

   function automatic logic [3:0] pick_op(input mix_type mix);
      int weight [10];
      int r;
      case (mix)
         MIX_FILL:  weight = '{22, 18, 6, 6, 20, 5, 10, 8, 2, 3};
         MIX_DRAIN: weight = '{8, 6, 20, 18, 6, 14, 12, 10, 3, 3};
         default:   weight = '{12, 10, 12, 12, 10, 10, 14, 12, 4, 4};
      endcase
      r = $urandom_range(99);
      for (int k = 0; k < 9; k++) begin
         if (r < weight[k]) return OP_ORDER[k];
         r -= weight[k];
      end
      return 4'($urandom_range(OP_UNUSED_TOP, ile_pkg::OP_CLEAR + 1));
   endfunction

   task automatic run_random(input int items);
      mix_type    mix;
      int         useful;
      logic [3:0] op;
      mix    = MIX_EVEN;
      useful = 0;
      while (useful < items) begin
         if ($urandom_range(39) == 0) mix = mix_type'($urandom_range(2));
         op = pick_op(mix);
         send_req(op, 4'($urandom_range(15)), pick_word(op == ile_pkg::OP_FIND ? 70 : 40));
         if (op <= ile_pkg::OP_CLEAR) useful++;
      end
   endtask

   initial begin
      word_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                    $urandom(), $urandom(), $urandom(), $urandom()};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Everything that can go wrong on an empty list, plus an unused code.
      send_req(ile_pkg::OP_READ, 4'd0, '0);
      send_req(ile_pkg::OP_TAKE, 4'd15, '0);
      send_req(ile_pkg::OP_POP, 4'd0, '0);
      send_req(ile_pkg::OP_DELETE, 4'd0, '0);
      send_req(ile_pkg::OP_FIND, 4'd0, '0);
      send_req(OP_UNUSED_TOP, 4'd15, 32'hFFFF_FFFF);
      // Appends past the end, then fill the list to capacity.
      send_req(ile_pkg::OP_INSERT, 4'd15, 32'h0000_0000);
      send_req(ile_pkg::OP_REPLACE, 4'd9, 32'hFFFF_FFFF);
      send_req(ile_pkg::OP_INSERT, 4'd0, 32'hA5A5_A5A5);
      for (int i = 0; i < 13; i++)
         send_req((i % 2) ? ile_pkg::OP_PUSH : ile_pkg::OP_INSERT, 4'(i), $urandom());
      send_req(ile_pkg::OP_INSERT, 4'd3, 32'h1234_5678);
      send_req(ile_pkg::OP_PUSH, 4'd0, 32'h8765_4321);
      send_req(ile_pkg::OP_REPLACE, 4'd15, 32'h5A5A_5A5A);
      send_req(ile_pkg::OP_FIND, 4'd0, 32'hFFFF_FFFF);
      send_req(ile_pkg::OP_FIND, 4'd0, 32'h0BAD_F00D);
      send_req(ile_pkg::OP_READ, 4'd15, '0);
      send_req(ile_pkg::OP_TAKE, 4'd15, '0);
      send_req(ile_pkg::OP_TAKE, 4'd15, '0);
      send_req(ile_pkg::OP_DELETE, 4'd15, '0);
      send_req(ile_pkg::OP_READ, 4'd14, '0);
      send_req(ile_pkg::OP_DELETE, 4'd2, '0);
      send_req(ile_pkg::OP_POP, 4'd0, '0);
      send_req(ile_pkg::OP_CLEAR, 4'd0, '0);

      run_random(PHASE_ITEMS);
      send_idle = 86;
      recv_idle = 16;
      run_random(PHASE_ITEMS);
      send_idle = 0;
      recv_idle = 0;
      hold_go   = 1'b1;
      run_random(PHASE_ITEMS);

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests under three idle mixes and a %0d-cycle response hold-off.",
               items_sent, HOLD_CYCLES);
      $display("Checked %0d responses: %0d writes dropped on a full list, %0d empty removals.",
               checked_count, full_drops, empty_misses);
      if (mismatches == 0 && outstanding == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_ram.sv
rtl/ile_seq.sv
rtl/indexed_list_engine.sv
rtl/ile_check.sv
verif/indexed_list_checker.sv
verif/testbench.sv
